// File: rtl/npcs_pkg.sv
package npcs_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int AW            = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int USED_MAX      = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;
  localparam int SIZE_W        = 9;
  localparam int DIST_W        = 10;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FIND  = 2'd1,
    OP_READ  = 2'd2
  } npcs_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIND_OUT,
    ST_READ,
    ST_READ_OUT
  } npcs_state_t;

  typedef struct packed {
    logic capture;
    logic wr_en;
    logic scan_start;
    logic scan_rd;
    logic rd_item;
    logic load_find;
    logic load_read;
  } npcs_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } npcs_stat_t;

endpackage

// File: rtl/npcs_ctrl.sv
module npcs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_opcode,
  output logic                 in_ready,
  input  npcs_pkg::npcs_stat_t stat,
  output npcs_pkg::npcs_cmd_t  cmd
);

  npcs_pkg::npcs_state_t state_r, state_nxt;
  npcs_pkg::npcs_op_t    op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npcs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    op        = npcs_pkg::npcs_op_t'(in_opcode);
    in_ready  = 1'b0;
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      npcs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (op)
            npcs_pkg::OP_WRITE: cmd.wr_en = 1'b1;
            npcs_pkg::OP_FIND: begin
              cmd.scan_start = 1'b1;
              state_nxt      = npcs_pkg::ST_SCAN;
            end
            npcs_pkg::OP_READ: state_nxt = npcs_pkg::ST_READ;
            default: state_nxt = npcs_pkg::ST_IDLE;
          endcase
        end
      end
      npcs_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_nxt = npcs_pkg::ST_DRAIN;
        end
      end
      // last entry's data is compared at the end of this cycle
      npcs_pkg::ST_DRAIN: state_nxt = npcs_pkg::ST_FIND_OUT;
      npcs_pkg::ST_FIND_OUT: begin
        if (!stat.out_busy) begin
          cmd.load_find = 1'b1;
          state_nxt     = npcs_pkg::ST_IDLE;
        end
      end
      npcs_pkg::ST_READ: begin
        cmd.rd_item = 1'b1;
        state_nxt   = npcs_pkg::ST_READ_OUT;
      end
      npcs_pkg::ST_READ_OUT: begin
        if (!stat.out_busy) begin
          cmd.load_read = 1'b1;
          state_nxt     = npcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = npcs_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/npcs_dpath.sv
module npcs_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [8:0]           cfg_palette_size,
  input  logic [7:0]           in_entry_index,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  npcs_pkg::npcs_cmd_t  cmd,
  output npcs_pkg::npcs_stat_t stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [7:0]           out_found_index,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic                 out_index_beyond_size
);

  localparam int AW = npcs_pkg::AW;

  logic [23:0] mem [npcs_pkg::PALETTE_DEPTH];
  logic [23:0] rdata_r;
  logic [AW-1:0] rd_addr;

  logic [npcs_pkg::SIZE_W-1:0] size_r;
  logic [npcs_pkg::SIZE_W-1:0] used_n;
  logic [npcs_pkg::SIZE_W-1:0] used_m1;

  logic [7:0] idx_r, q_red_r, q_green_r, q_blue_r;

  logic [AW-1:0] cnt_r;
  logic          cmp_vld_r;
  logic [AW-1:0] cmp_idx_r;

  logic [npcs_pkg::DIST_W-1:0] cur_dist;
  logic [npcs_pkg::DIST_W-1:0] best_dist_r;
  logic [7:0]                  best_idx_r;
  logic [23:0]                 best_color_r;
  logic [7:0]                  d_red, d_green, d_blue;

  logic wr_in_store, rd_in_store;
  logic out_valid_r;

  // clamp the size register to the entries in use
  always_comb begin
    used_n = size_r;
    if (used_n == '0) begin
      used_n = npcs_pkg::SIZE_W'(1);
    end
    if (32'(used_n) > npcs_pkg::USED_MAX) begin
      used_n = npcs_pkg::SIZE_W'(npcs_pkg::USED_MAX);
    end
    used_m1 = used_n - npcs_pkg::SIZE_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= npcs_pkg::SIZE_W'(256);
    end else if (cfg_wr_en) begin
      size_r <= cfg_palette_size;
    end
  end

  assign wr_in_store = (32'(in_entry_index) < npcs_pkg::PALETTE_DEPTH);
  assign rd_in_store = (32'(idx_r) < npcs_pkg::PALETTE_DEPTH);
  assign rd_addr     = cmd.scan_rd ? cnt_r : AW'(idx_r);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_in_store) begin
      mem[AW'(in_entry_index)] <= {in_red, in_green, in_blue};
    end
    if (cmd.scan_rd || cmd.rd_item) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r     <= in_entry_index;
      q_red_r   <= in_red;
      q_green_r <= in_green;
      q_blue_r  <= in_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      cnt_r <= '0;
    end else if (cmd.scan_rd) begin
      cnt_r <= cnt_r + AW'(1);
    end
    cmp_idx_r <= cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_rd;
    end
  end

  assign stat.scan_last = (32'(cnt_r) == 32'(used_m1));

  always_comb begin
    d_red    = (rdata_r[23:16] > q_red_r)   ? rdata_r[23:16] - q_red_r
                                            : q_red_r - rdata_r[23:16];
    d_green  = (rdata_r[15:8] > q_green_r)  ? rdata_r[15:8] - q_green_r
                                            : q_green_r - rdata_r[15:8];
    d_blue   = (rdata_r[7:0] > q_blue_r)    ? rdata_r[7:0] - q_blue_r
                                            : q_blue_r - rdata_r[7:0];
    cur_dist = npcs_pkg::DIST_W'(d_red) + npcs_pkg::DIST_W'(d_green)
             + npcs_pkg::DIST_W'(d_blue);
  end

  // strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      best_dist_r <= '1;
    end else if (cmp_vld_r && (cur_dist < best_dist_r)) begin
      best_dist_r  <= cur_dist;
      best_idx_r   <= 8'(cmp_idx_r);
      best_color_r <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_find || cmd.load_read) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_find) begin
      out_found_index       <= best_idx_r;
      {out_red, out_green, out_blue} <= best_color_r;
      out_index_beyond_size <= 1'b0;
    end else if (cmd.load_read) begin
      out_found_index       <= idx_r;
      {out_red, out_green, out_blue} <= rd_in_store ? rdata_r : 24'd0;
      out_index_beyond_size <= (npcs_pkg::SIZE_W'(idx_r) >= used_n);
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.out_busy = out_valid_r && !out_ready;

endmodule

// File: rtl/nearest_palette_color_search_top.sv
// Nearest palette color search. Write items (opcode 0) load one RGB palette
// entry and give no result; a write to an index outside the store is dropped.
// Find items (opcode 1) return the index and color of the first entry, from
// index zero among the palette_size entries in use, with the smallest sum of
// absolute component differences; ties go to the lowest index. Read items
// (opcode 2) return the stored color at an index and flag an index that is
// not below the size in use. Opcode 3 is dropped. A write is done when taken;
// a read passes the read and read-out states, a find the scan, drain and
// find-out states, the search streaming one entry per cycle through the
// single read port of the palette memory. The result sits in an output
// register, so the next item is taken while a result waits; a find or read
// that finishes while the previous result still waits holds in its last state
// until that result is taken. Palette contents are undefined until written;
// there is no clearing pass. Change palette_size only while idle.
module nearest_palette_color_search_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_palette_size,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_entry_index,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_found_index,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_index_beyond_size
);

  npcs_pkg::npcs_cmd_t  cmd;
  npcs_pkg::npcs_stat_t stat;

  // sequence each item: accept, scan or read, load the output register
  npcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // palette memory, distance compare, best tracking and output register
  npcs_dpath u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_palette_size      (cfg_palette_size),
    .in_entry_index        (in_entry_index),
    .in_red                (in_red),
    .in_green              (in_green),
    .in_blue               (in_blue),
    .cmd                   (cmd),
    .stat                  (stat),
    .out_ready             (out_ready),
    .out_valid             (out_valid),
    .out_found_index       (out_found_index),
    .out_red               (out_red),
    .out_green             (out_green),
    .out_blue              (out_blue),
    .out_index_beyond_size (out_index_beyond_size)
  );

`ifndef SYNTHESIS
  // a write item never produces a result
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_opcode == 2'(npcs_pkg::OP_WRITE)) && !out_valid)
    |=> !out_valid)
    else $error("write item produced a result");

  // never overwrite a result that is still waiting
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_find || cmd.load_read) |-> !(out_valid && !out_ready))
    else $error("output register loaded while stalled");

  // a find result shows up with the beyond-size flag clear
  a_find_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_find |=> (out_valid && !out_index_beyond_size))
    else $error("find result malformed");

  // no new item is taken while the palette is being walked
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_rd || cmd.rd_item) |-> !in_ready)
    else $error("item accepted during scan or read");
`endif

endmodule

// File: verif/npcs_result_checker.sv
`timescale 1ns / 100ps
module npcs_result_checker
  import npcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_palette_size,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_entry_index,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_found_index,
  input  logic [7:0] out_red,
  input  logic [7:0] out_green,
  input  logic [7:0] out_blue,
  input  logic       out_index_beyond_size,
  output int         fail_count,
  output int         outstanding
);

  typedef struct {
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       beyond;
  } palette_reply_t;

  logic [23:0]       color_mem [PALETTE_DEPTH];
  logic [SIZE_W-1:0] size_reg;
  palette_reply_t    reply_q [$];
  int                mismatches;

  // Zero counts as one entry; large sizes saturate at the store depth.
  function automatic int entries_in_use();
    int n;
    n = int'(size_reg);
    if (n == 0) n = 1;
    if (n > USED_MAX) n = USED_MAX;
    return n;
  endfunction

  function automatic int channel_gap(logic [7:0] a, logic [7:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // Strict less-than keeps the lowest index on a tie.
  function automatic palette_reply_t search_nearest(logic [7:0] r, logic [7:0] g,
                                                    logic [7:0] b);
    palette_reply_t rep;
    int             best;
    int             best_dist;
    int             gap_sum;
    logic [23:0]    c;
    best      = 0;
    best_dist = 1 << 30;
    for (int i = 0; i < entries_in_use(); i++) begin
      c       = color_mem[i];
      gap_sum = channel_gap(c[23:16], r) + channel_gap(c[15:8], g)
              + channel_gap(c[7:0], b);
      if (gap_sum < best_dist) begin
        best_dist = gap_sum;
        best      = i;
      end
    end
    c          = color_mem[best];
    rep.index  = 8'(best);
    rep.red    = c[23:16];
    rep.green  = c[15:8];
    rep.blue   = c[7:0];
    rep.beyond = 1'b0;
    return rep;
  endfunction

  function automatic palette_reply_t read_entry(logic [7:0] idx);
    palette_reply_t rep;
    logic [23:0]    c;
    c          = (int'(idx) < PALETTE_DEPTH) ? color_mem[idx] : 24'd0;
    rep.index  = idx;
    rep.red    = c[23:16];
    rep.green  = c[15:8];
    rep.blue   = c[7:0];
    rep.beyond = (int'(idx) >= entries_in_use());
    return rep;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    palette_reply_t want;
    if (!rst_n) begin
      reply_q.delete();
      size_reg   = 9'd256;
      mismatches = 0;
    end else begin
      if (cfg_wr_en) size_reg = cfg_palette_size;
      // Results leave a register, so one accepted now belongs to an older item.
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("result with nothing pending, found_index", 0,
                          32'(out_found_index));
        end else begin
          want = reply_q.pop_front();
          if (out_found_index !== want.index)
            report_mismatch("found_index", 32'(want.index), 32'(out_found_index));
          if (out_red !== want.red)
            report_mismatch("out_red", 32'(want.red), 32'(out_red));
          if (out_green !== want.green)
            report_mismatch("out_green", 32'(want.green), 32'(out_green));
          if (out_blue !== want.blue)
            report_mismatch("out_blue", 32'(want.blue), 32'(out_blue));
          if (out_index_beyond_size !== want.beyond)
            report_mismatch("index_beyond_size", 32'(want.beyond),
                            32'(out_index_beyond_size));
        end
      end
      if (in_valid && in_ready) begin
        case (in_opcode)
          OP_WRITE: begin
            if (int'(in_entry_index) < PALETTE_DEPTH)
              color_mem[in_entry_index] = {in_red, in_green, in_blue};
          end
          OP_FIND: reply_q.push_back(search_nearest(in_red, in_green, in_blue));
          OP_READ: reply_q.push_back(read_entry(in_entry_index));
          default: ;
        endcase
      end
    end
    fail_count  <= mismatches;
    outstanding <= reply_q.size();
  end

endmodule

// File: verif/tb_nearest_palette_color_search_top.sv
`timescale 1ns / 100ps
module tb_nearest_palette_color_search_top;
  import npcs_pkg::*;

  // The fourth opcode has no meaning; the block must drop it.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_PCT = 16;
  // A write lands at the edge that takes it; keep a margin before a size
  // change anyway.
  localparam int SETTLE_CYCLES = 8;
  // Slowest correct run: about 1800 items, each at most a full-palette search
  // plus idle gaps on both sides. The limit allows a wide margin over that.
  localparam int CYCLE_LIMIT = 3_000_000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [8:0] cfg_palette_size = 9'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_opcode = 2'd0;
  logic [7:0] in_entry_index = 8'd0;
  logic [7:0] in_red = 8'd0;
  logic [7:0] in_green = 8'd0;
  logic [7:0] in_blue = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_found_index;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       out_index_beyond_size;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  bit quiet = 1'b0;

  // Stimulus-side record of the palette: which entries hold a color, and
  // which color. Finds and reads only touch written entries.
  bit          loaded [256];
  logic [23:0] loaded_color [256];
  int          size_in_use = 256;

  nearest_palette_color_search_top dut (.*);

  npcs_result_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random, except during the quiet stretch.
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: fail the run at the cycle limit, so a hang cannot run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int lowest_gap();
    for (int i = 0; i < 256; i++)
      if (!loaded[i]) return i;
    return 256;
  endfunction

  // Favor the corner levels now and then so ties and extremes show up.
  function automatic logic [7:0] pick_level();
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 2))
        0: return 8'd0;
        1: return 8'd128;
        default: return 8'd255;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Present one item and hold it until taken. Drop valid only for an idle gap.
  task automatic send_item(logic [1:0] op, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_entry_index <= idx;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    do @(posedge clk); while (!in_ready);
    if (op == OP_WRITE) begin
      loaded[idx]       = 1'b1;
      loaded_color[idx] = {r, g, b};
    end
  endtask

  // Change the size only once the block is idle: every result back, plus a
  // margin for a trailing write.
  task automatic set_size(logic [8:0] sz);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en        <= 1'b1;
    cfg_palette_size <= sz;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    size_in_use = (sz == 0) ? 1 : ((int'(sz) > USED_MAX) ? USED_MAX : int'(sz));
  endtask

  // One random phase at a given size. A find before the entries in use are all
  // written turns into a write that fills the lowest hole; a read of an empty
  // entry turns into a write of it.
  task automatic run_phase(logic [8:0] sz, int count, int find_pct, int read_pct);
    int          roll;
    int          gap;
    logic [7:0]  idx;
    logic [23:0] c;
    set_size(sz);
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      idx  = 8'($urandom_range(0, 255));
      gap  = lowest_gap();
      if (roll < 3) begin
        send_item(OP_UNUSED, idx, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (roll < 3 + find_pct) begin
        if (gap < size_in_use) begin
          send_item(OP_WRITE, 8'(gap), pick_level(), pick_level(), pick_level());
        end else begin
          // Aim at a stored color: exact, nudged, or anywhere at all.
          c = loaded_color[$urandom_range(0, size_in_use - 1)];
          case ($urandom_range(0, 4))
            0, 1: ;
            2: c = c ^ {5'd0, 3'($urandom), 5'd0, 3'($urandom), 5'd0, 3'($urandom)};
            default: c = 24'($urandom);
          endcase
          send_item(OP_FIND, idx, c[23:16], c[15:8], c[7:0]);
        end
      end else if (roll < 3 + find_pct + read_pct) begin
        if ($urandom_range(0, 1) == 1) idx = 8'($urandom_range(0, size_in_use - 1));
        if (loaded[idx])
          send_item(OP_READ, idx, 8'($urandom), 8'($urandom), 8'($urandom));
        else
          send_item(OP_WRITE, idx, pick_level(), pick_level(), pick_level());
      end else begin
        if ($urandom_range(0, 9) < 3 && gap < 256) idx = 8'(gap);
        send_item(OP_WRITE, idx, pick_level(), pick_level(), pick_level());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: four entries in use plus one at the top index.
    set_size(9'd4);
    send_item(OP_WRITE, 8'd0, 8'd0, 8'd0, 8'd0);
    send_item(OP_WRITE, 8'd1, 8'd255, 8'd255, 8'd255);
    send_item(OP_WRITE, 8'd2, 8'd255, 8'd0, 8'd0);
    send_item(OP_WRITE, 8'd3, 8'd0, 8'd255, 8'd0);
    send_item(OP_WRITE, 8'd255, 8'd0, 8'd0, 8'd255);
    // Exact matches at both color extremes; the index field is ignored.
    send_item(OP_FIND, 8'd0, 8'd0, 8'd0, 8'd0);
    send_item(OP_FIND, 8'd255, 8'd255, 8'd255, 8'd255);
    // Entries two and three are equally near: the lower index wins.
    send_item(OP_FIND, 8'd7, 8'd128, 8'd128, 8'd0);
    send_item(OP_FIND, 8'd0, 8'd1, 8'd254, 8'd0);
    send_item(OP_READ, 8'd3, 8'd0, 8'd0, 8'd0);
    // Read beyond the size in use: flag set, stored color still returned.
    send_item(OP_READ, 8'd255, 8'd255, 8'd255, 8'd255);
    // Unused opcode must leave entry zero alone and give no result.
    send_item(OP_UNUSED, 8'd0, 8'd170, 8'd85, 8'd170);
    send_item(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0);
    // Duplicate of entry zero: an exact tie still goes to index zero.
    send_item(OP_WRITE, 8'd3, 8'd0, 8'd0, 8'd0);
    send_item(OP_FIND, 8'd3, 8'd0, 8'd0, 8'd0);
    // A size of zero acts as one entry.
    set_size(9'd0);
    send_item(OP_FIND, 8'd0, 8'd200, 8'd100, 8'd50);
    send_item(OP_READ, 8'd1, 8'd0, 8'd0, 8'd0);
    send_item(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0);

    // Random phases: mostly small palettes, a few full ones.
    run_phase(9'd7, 250, 35, 25);
    run_phase(9'd1, 100, 40, 30);
    run_phase(9'd2, 150, 40, 25);
    run_phase(9'd256, 250, 12, 20);
    quiet <= 1'b1;
    run_phase(9'd33, 300, 40, 25);
    quiet <= 1'b0;
    // Above the store depth: saturates at the full palette.
    run_phase(9'd511, 100, 15, 20);
    run_phase(9'($urandom_range(1, 256)), 300, 35, 25);
    run_phase(9'd255, 150, 20, 20);
    run_phase(9'd3, 150, 45, 25);

    // Drain: wait for every pending result, then idle on to catch stray ones.
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
